// File: sv/stk_pkg.sv
`default_nettype none

package stk_pkg;

    localparam int MAX_NAME  = 9;
    localparam int CNT_W     = $clog2(MAX_NAME + 1);
    localparam int IDX_W     = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
    localparam int NAME_BITS = 72;
    localparam int LEN_W     = 4;
    localparam int POS_W     = 32;
    localparam int OUT_DATA_W = 144;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_F       = 8'h66;

    typedef enum logic [3:0] {
        K_INC        = 4'd0,
        K_DEC        = 4'd1,
        K_PRINT      = 4'd2,
        K_NEXT       = 4'd3,
        K_PREV       = 4'd4,
        K_LOOP_START = 4'd5,
        K_LOOP_END   = 4'd6,
        K_ASSIGN     = 4'd7,
        K_STMT_END   = 4'd8,
        K_REF        = 4'd9,
        K_READ       = 4'd10,
        K_DEF        = 4'd11,
        K_IDENT      = 4'd12,
        K_ERROR      = 4'd13,
        K_END        = 4'd14
    } kind_t;

    typedef struct packed {
        logic                 valid;
        kind_t                kind;
    } punct_t;

    // results one byte can cause: a name slot, a punctuation slot, an end slot
    typedef struct packed {
        logic                 has_name;
        kind_t                name_kind;
        logic [NAME_BITS-1:0] name_data;
        logic [LEN_W-1:0]     name_len;
        logic [POS_W-1:0]     name_pos;
        logic                 name_done;
        logic                 has_punct;
        kind_t                punct_kind;
        logic                 has_end;
        logic [POS_W-1:0]     end_count;
    } grp_t;

    function automatic logic is_name_byte(input logic [7:0] c);
        logic r;
        r = (c inside {[8'h41:8'h5a], [8'h61:8'h7a], 8'h5f});
        return r;
    endfunction

    function automatic punct_t punct_lookup(input logic [7:0] c);
        punct_t p;
        p.valid = 1'b1;
        p.kind  = K_INC;
        case (c)
            8'h2b:   p.kind = K_INC;
            8'h2d:   p.kind = K_DEC;
            8'h2e:   p.kind = K_PRINT;
            8'h3e:   p.kind = K_NEXT;
            8'h3c:   p.kind = K_PREV;
            8'h5b:   p.kind = K_LOOP_START;
            8'h5d:   p.kind = K_LOOP_END;
            8'h3d:   p.kind = K_ASSIGN;
            8'h3b:   p.kind = K_STMT_END;
            8'h2a:   p.kind = K_REF;
            8'h2c:   p.kind = K_READ;
            default: p.valid = 1'b0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: sv/source_tokenizer.sv
// path: a byte taken is held in the input register (ch_reg); its results are then
//   loaded into the result register (grp_reg, pend_reg), which sends them out
// throughput: one byte per cycle while m_axis_tready is high and each byte
//   gives at most one token; a byte giving several tokens (name flush, punctuation, end)
//   holds the input until its last token is sent, since the result register sends one token per cycle
// reset: rst_n clears the tokenizer state and the pending results at once,
//   with no clearing pass; the name buffer is not cleared
`default_nettype none

module source_tokenizer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // ch[7:0]
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // name_low[63:0], name_high[71:64], name_len[75:72], position[107:76],
    // count[139:108], zero fill[143:140]
    output logic [stk_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast,
    output logic [3:0]                         m_axis_tuser   // kind[3:0]
);
    import stk_pkg::*;

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       last_reg;
    logic       out_free;
    logic       proc_fire;
    grp_t       grp;

    assign proc_fire     = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            ch_reg   <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    stk_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (proc_fire),
        .ch    (ch_reg),
        .last  (last_reg),
        .grp   (grp)
    );

    stk_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (proc_fire),
        .grp           (grp),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: sv/stk_scan.sv
`default_nettype none

module stk_scan (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire logic [7:0]    ch,
    input  wire logic          last,
    output stk_pkg::grp_t      grp
);
    import stk_pkg::*;

    logic                 at_line_start_reg;
    logic [CNT_W-1:0]     name_count_reg;
    logic                 name_began_line_reg;
    logic [POS_W-1:0]     name_start_reg;
    logic [POS_W-1:0]     byte_pos_reg;
    logic [POS_W-1:0]     token_total_reg;
    logic                 halted_reg;
    logic [7:0]           name_buf_reg [MAX_NAME];

    logic                 name_byte;
    logic                 err;
    logic                 do_flush;
    logic                 by_space;
    logic                 is_def;
    punct_t               pl;
    logic                 has_punct;
    logic [CNT_W-1:0]     flush_len;
    logic [POS_W-1:0]     start_e;
    logic                 began_e;
    logic [7:0]           buf_e [MAX_NAME];
    logic [NAME_BITS-1:0] packed_name;
    logic [POS_W:0]       total_sum;
    logic [POS_W-1:0]     total_next;

    always_comb
    begin
        name_byte = is_name_byte(ch);
        pl        = punct_lookup(ch);
        err       = !halted_reg && name_byte && (name_count_reg >= CNT_W'(MAX_NAME));
        start_e   = (name_count_reg == '0) ? byte_pos_reg : name_start_reg;
        began_e   = (name_count_reg == '0) ? at_line_start_reg : name_began_line_reg;
        flush_len = name_byte ? name_count_reg + CNT_W'(1) : name_count_reg;
        do_flush  = !halted_reg && !err &&
                    ((!name_byte && name_count_reg != '0) || (name_byte && last));
        by_space  = !name_byte && (ch == CH_SPACE);
        has_punct = !halted_reg && !name_byte && pl.valid;

        // buffer as it stands once this byte is written
        for (int j = 0; j < MAX_NAME; j++)
        begin
            buf_e[j] = (name_byte && name_count_reg == CNT_W'(j)) ? ch : name_buf_reg[j];
        end
        packed_name = '0;
        for (int j = 0; j < MAX_NAME; j++)
        begin
            if (CNT_W'(j) < flush_len)
            begin
                packed_name[8*j +: 8] = buf_e[j];
            end
        end

        is_def = (flush_len == CNT_W'(3)) && began_e && by_space &&
                 (buf_e[0] == CH_D) && (buf_e[1] == CH_E) && (buf_e[2] == CH_F);

        total_sum  = {1'b0, token_total_reg} + (POS_W+1)'(do_flush) + (POS_W+1)'(has_punct);
        total_next = total_sum[POS_W] ? '1 : total_sum[POS_W-1:0];

        grp            = '0;
        grp.punct_kind = pl.kind;
        grp.name_kind  = K_IDENT;
        if (err)
        begin
            grp.has_name  = 1'b1;
            grp.name_kind = K_ERROR;
            grp.name_pos  = start_e;
            grp.name_done = 1'b1;
        end
        else if (do_flush)
        begin
            grp.has_name = 1'b1;
            if (is_def)
            begin
                grp.name_kind = K_DEF;
            end
            else
            begin
                grp.name_kind = K_IDENT;
                grp.name_data = packed_name;
                grp.name_len  = LEN_W'(flush_len);
                grp.name_pos  = start_e;
            end
        end
        grp.has_punct = has_punct;
        grp.has_end   = !halted_reg && !err && last;
        grp.end_count = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg   <= 1'b1;
            name_count_reg      <= '0;
            name_began_line_reg <= 1'b0;
            name_start_reg      <= '0;
            byte_pos_reg        <= '0;
            token_total_reg     <= '0;
            halted_reg          <= 1'b0;
        end
        else if (fire && !halted_reg)
        begin
            if (err)
            begin
                halted_reg <= 1'b1;
            end
            else if (last)
            begin
                // start of a new program
                at_line_start_reg   <= 1'b1;
                name_count_reg      <= '0;
                name_began_line_reg <= 1'b0;
                name_start_reg      <= '0;
                byte_pos_reg        <= '0;
                token_total_reg     <= '0;
            end
            else
            begin
                at_line_start_reg <= (ch == CH_NEWLINE);
                byte_pos_reg      <= byte_pos_reg + POS_W'(1);
                token_total_reg   <= total_next;
                name_count_reg    <= name_byte ? flush_len : '0;
                if (name_byte && name_count_reg == '0)
                begin
                    name_start_reg      <= byte_pos_reg;
                    name_began_line_reg <= at_line_start_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && !halted_reg && name_byte && !err)
        begin
            name_buf_reg[name_count_reg[IDX_W-1:0]] <= ch;
        end
    end

endmodule

`default_nettype wire

// File: sv/stk_out.sv
`default_nettype none

module stk_out (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire stk_pkg::grp_t                 grp,
    output logic                               free,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [stk_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast,
    output logic [3:0]                         m_axis_tuser
);
    import stk_pkg::*;

    // pending slots: bit 0 name, bit 1 punctuation, bit 2 end
    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    grp_t       grp_reg;
    logic       m_fire;

    logic [63:0]      o_low;
    logic [7:0]       o_high;
    logic [LEN_W-1:0] o_len;
    logic [POS_W-1:0] o_pos;
    logic [POS_W-1:0] o_count;
    kind_t            o_kind;
    logic             o_done;

    always_comb
    begin
        m_fire = m_axis_tvalid && m_axis_tready;
        free   = (pend_reg == 3'b000) || ($onehot(pend_reg) && m_axis_tready);
        if (load)
        begin
            pend_next = {grp.has_end, grp.has_punct, grp.has_name};
        end
        else if (m_fire)
        begin
            pend_next = pend_reg & (pend_reg - 3'd1);
        end
        else
        begin
            pend_next = pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'b000;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp;
        end
    end

    always_comb
    begin
        o_low   = '0;
        o_high  = '0;
        o_len   = '0;
        o_pos   = '0;
        o_count = '0;
        o_done  = 1'b0;
        o_kind  = K_END;
        if (pend_reg[0])
        begin
            o_kind = grp_reg.name_kind;
            o_low  = grp_reg.name_data[63:0];
            o_high = grp_reg.name_data[71:64];
            o_len  = grp_reg.name_len;
            o_pos  = grp_reg.name_pos;
            o_done = grp_reg.name_done;
        end
        else if (pend_reg[1])
        begin
            o_kind = grp_reg.punct_kind;
        end
        else
        begin
            o_kind  = K_END;
            o_count = grp_reg.end_count;
            o_done  = 1'b1;
        end
        m_axis_tvalid = (pend_reg != 3'b000);
        m_axis_tdata  = {4'b0000, o_count, o_pos, o_len, o_high, o_low};
        m_axis_tlast  = o_done;
        m_axis_tuser  = o_kind;
    end

endmodule

`default_nettype wire
